// ----- sv/permutation_unrank_unit_macros.svh -----
// ----------------------------------------------------------------------------
// Permutation unrank unit - assertion macros
// Shared concurrent assertion forms, clocked on the rising edge and
// disabled while reset is high.
// ----------------------------------------------------------------------------
`ifndef PERMUTATION_UNRANK_UNIT_MACROS_SVH
`define PERMUTATION_UNRANK_UNIT_MACROS_SVH

// Same-cycle implication
`define PRU_ASSERT_IMP(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication
`define PRU_ASSERT_NXT(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ----- sv/pru_pkg.sv -----
// ----------------------------------------------------------------------------
// Permutation unrank package
// Field widths, divider step constants, sequencer states and the divider
// status bundle.
// ----------------------------------------------------------------------------
package pru_pkg;

  // Field widths
  localparam int RANK_W = 45;
  localparam int POS_W  = 4;
  localparam int ELEM_W = 4;
  localparam int CFG_W  = 5;

  localparam logic [CFG_W-1:0] CFG_RESET = 5'd16;

  // Divider: quotient bits retired per cycle and steps per division
  localparam int DIV_BITS  = 5;
  localparam int DIV_STEPS = RANK_W / DIV_BITS;

  // Sequencer states
  typedef enum logic [2:0] {
    S_IDLE,
    S_INIT,
    S_START,
    S_WAIT,
    S_READ,
    S_WR_A,
    S_WR_B,
    S_OUT
  } state_t;

  // Divider status
  typedef struct packed {
    logic busy;
    logic done;
  } div_stat_t;

endpackage

// ----- sv/pru_if.sv -----
// ----------------------------------------------------------------------------
// Permutation unrank channel interfaces
// Valid/ready channels for the configuration write, the rank request and
// the element results.
// ----------------------------------------------------------------------------

// Configuration write channel
interface pru_cfg_if import pru_pkg::*; ();
  logic             valid;
  logic             ready;
  logic [CFG_W-1:0] data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

// Rank request channel
interface pru_rank_if import pru_pkg::*; ();
  logic              valid;
  logic              ready;
  logic [RANK_W-1:0] rank;

  modport source (output valid, output rank, input ready);
  modport sink   (input valid, input rank, output ready);
endinterface

// Element result channel
interface pru_elem_if import pru_pkg::*; ();
  logic              valid;
  logic              ready;
  logic [POS_W-1:0]  position;
  logic [ELEM_W-1:0] element;
  logic              last;

  modport source (output valid, output position, output element, output last,
                  input ready);
  modport sink   (input valid, input position, input element, input last,
                  output ready);
endinterface

// ----- sv/pru_ram.sv -----
// ----------------------------------------------------------------------------
// Generic RAM
// One write port and two read ports, read data registered.
// ----------------------------------------------------------------------------
module pru_ram #(
  parameter int WIDTH = 4,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr0,
  input  logic [$clog2(DEPTH)-1:0] raddr1,
  output logic [WIDTH-1:0]         rdata0,
  output logic [WIDTH-1:0]         rdata1
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write and registered reads
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata0 <= mem[raddr0];
    rdata1 <= mem[raddr1];
  end

endmodule

// ----- sv/pru_div.sv -----
// ----------------------------------------------------------------------------
// Iterative rank divider
// Restoring division of the rank by a small divisor, several quotient bits
// per cycle; quotient and remainder are valid on the done pulse.
// ----------------------------------------------------------------------------
`include "permutation_unrank_unit_macros.svh"

module pru_div import pru_pkg::*; #(
  parameter int DIV_W = 5
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              start,
  input  logic [RANK_W-1:0] dividend,
  input  logic [DIV_W-1:0]  divisor,
  output div_stat_t         stat,
  output logic [RANK_W-1:0] quotient,
  output logic [DIV_W-1:0]  remainder
);

  localparam int CNT_W = $clog2(DIV_STEPS);

  logic              busy;
  logic              done;
  logic [CNT_W-1:0]  cnt;
  logic [RANK_W-1:0] acc;
  logic [DIV_W-1:0]  rem;
  logic [DIV_W-1:0]  dvs;
  logic [RANK_W-1:0] acc_next;
  logic [DIV_W-1:0]  rem_next;

  // Retire DIV_BITS quotient bits: shift in the top dividend bit, subtract
  always_comb begin
    logic [DIV_W:0] cand;
    acc_next = acc;
    rem_next = rem;
    for (int j = 0; j < DIV_BITS; j++) begin
      cand     = {rem_next, acc_next[RANK_W-1]};
      acc_next = {acc_next[RANK_W-2:0], 1'b0};
      if (cand >= {1'b0, dvs}) begin
        rem_next    = DIV_W'(cand - {1'b0, dvs});
        acc_next[0] = 1'b1;
      end else begin
        rem_next = DIV_W'(cand);
      end
    end
  end

  // Control: load on start, count steps, pulse done at the end
  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        cnt  <= '0;
      end else if (busy) begin
        cnt <= cnt + 1'b1;
        if (cnt == CNT_W'(DIV_STEPS - 1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  // Datapath: operands load on start, then advance while busy
  always_ff @(posedge clk) begin
    if (start) begin
      acc <= dividend;
      rem <= '0;
      dvs <= divisor;
    end else if (busy) begin
      acc <= acc_next;
      rem <= rem_next;
    end
  end

  assign stat.busy = busy;
  assign stat.done = done;
  assign quotient  = acc;
  assign remainder = rem;

  `PRU_ASSERT_IMP(a_start_idle, clk, rst, start, !busy, "divider started while busy")
  `PRU_ASSERT_NXT(a_start_busy, clk, rst, start, busy, "divider not busy after start")
  `PRU_ASSERT_IMP(a_done_after, clk, rst, done, !busy && $past(busy), "stray divider done")

endmodule

// ----- sv/permutation_unrank_unit.sv -----
// ----------------------------------------------------------------------------
// Permutation unrank unit
// Turns a rank into a permutation of the configured length, one element
// per result beat in position order, with last on the final element.
// ----------------------------------------------------------------------------
// One rank is taken at a time; req.ready is high only while the unit is
// idle. For an effective length len (perm_length held to 1..MAX_ELEMENTS)
// an item runs in order: S_INIT writes the identity into the working RAM,
// S_START launches the first division, then each of the len steps waits
// in S_WAIT for the done pulse of the shared divider and swaps through the
// RAM's single write port (a read in S_READ, then writes in S_WR_A and
// S_WR_B, the second of which launches the next division while steps
// remain); the elements then stream out at one beat per cycle while the
// output is not stalled, after the registered RAM read, and the idle state
// takes the next rank. The last result may still wait in the output
// register while the next rank is accepted. Ranks of len! or more act as
// rank mod len!. Configuration is accepted at any time but must only be
// written while the unit is idle.
// ----------------------------------------------------------------------------
`include "permutation_unrank_unit_macros.svh"

module permutation_unrank_unit import pru_pkg::*; #(
  parameter int MAX_ELEMENTS = 16
) (
  input  logic        clk,
  input  logic        rst,
  pru_cfg_if.sink     cfg,
  pru_rank_if.sink    req,
  pru_elem_if.source  rsp
);

  localparam int LEN_W = $clog2(MAX_ELEMENTS + 1);
  localparam int IDX_W = $clog2(MAX_ELEMENTS);

  state_t state;
  state_t state_next;

  logic [CFG_W-1:0]  perm_length;
  logic [CFG_W-1:0]  len_clamp;
  logic [LEN_W-1:0]  len;
  logic [LEN_W-1:0]  n;
  logic [IDX_W-1:0]  idx;
  logic [IDX_W-1:0]  k;
  logic [IDX_W-1:0]  tmp;
  logic [IDX_W-1:0]  n_idx;
  logic [RANK_W-1:0] work_rank;
  logic              rd_valid;

  logic              out_valid;
  logic [POS_W-1:0]  out_position;
  logic [ELEM_W-1:0] out_element;
  logic              out_last;
  logic              out_load;
  logic              idx_last;

  logic              ram_we;
  logic [IDX_W-1:0]  ram_waddr;
  logic [IDX_W-1:0]  ram_wdata;
  logic [IDX_W-1:0]  ram_raddr0;
  logic [IDX_W-1:0]  ram_rdata0;
  logic [IDX_W-1:0]  ram_rdata1;

  logic              div_start;
  logic [LEN_W-1:0]  div_divisor;
  div_stat_t         div_stat;
  logic [RANK_W-1:0] div_quot;
  logic [LEN_W-1:0]  div_rem;

  logic              req_beat;

  // Configuration register
  assign cfg.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      perm_length <= CFG_RESET;
    end else if (cfg.valid) begin
      perm_length <= cfg.data;
    end
  end

  // Hold the length to 1..MAX_ELEMENTS
  always_comb begin
    if (perm_length == '0) begin
      len_clamp = CFG_W'(1);
    end else if (perm_length > CFG_W'(MAX_ELEMENTS)) begin
      len_clamp = CFG_W'(MAX_ELEMENTS);
    end else begin
      len_clamp = perm_length;
    end
  end

  assign req_beat = req.valid && req.ready;
  assign n_idx    = IDX_W'(n - 1'b1);
  assign idx_last = (idx == IDX_W'(len - 1'b1));
  assign out_load = (state == S_OUT) && rd_valid && (!out_valid || rsp.ready);

  // Next state
  always_comb begin
    state_next = state;
    unique case (state)
      S_IDLE:  if (req.valid) state_next = S_INIT;
      S_INIT:  if (idx_last) state_next = S_START;
      S_START: state_next = S_WAIT;
      S_WAIT:  if (div_stat.done) state_next = S_READ;
      S_READ:  state_next = S_WR_A;
      S_WR_A:  state_next = S_WR_B;
      S_WR_B:  state_next = (n == LEN_W'(1)) ? S_OUT : S_WAIT;
      S_OUT:   if (out_load && idx_last) state_next = S_IDLE;
      default: state_next = S_IDLE;
    endcase
  end

  // Outputs of the sequencer: RAM ports, divider launch, request ready
  always_comb begin
    ram_we      = 1'b0;
    ram_waddr   = idx;
    ram_wdata   = idx;
    ram_raddr0  = n_idx;
    div_start   = 1'b0;
    div_divisor = n;
    req.ready   = 1'b0;
    unique case (state) inside
      S_IDLE: begin
        req.ready = 1'b1;
      end
      S_INIT: begin
        ram_we = 1'b1;
      end
      S_START: begin
        div_start = 1'b1;
      end
      S_WAIT, S_READ: begin
        ram_raddr0 = n_idx;
      end
      S_WR_A: begin
        ram_we    = 1'b1;
        ram_waddr = n_idx;
        ram_wdata = ram_rdata1;
      end
      S_WR_B: begin
        ram_we      = 1'b1;
        ram_waddr   = k;
        ram_wdata   = tmp;
        div_start   = (n != LEN_W'(1));
        div_divisor = n - 1'b1;
      end
      S_OUT: begin
        ram_raddr0 = (out_load && !idx_last) ? idx + 1'b1 : idx;
      end
      default: begin
        req.ready = 1'b0;
      end
    endcase
  end

  // State register
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // Working registers: rank, length, step counter, swap operands
  always_ff @(posedge clk) begin
    if (rst) begin
      work_rank <= '0;
    end else if (req_beat) begin
      work_rank <= req.rank;
    end else if (state == S_WAIT && div_stat.done) begin
      work_rank <= div_quot;
    end
  end

  always_ff @(posedge clk) begin
    if (req_beat) begin
      len <= LEN_W'(len_clamp);
      n   <= LEN_W'(len_clamp);
      idx <= '0;
    end
    if (state == S_INIT && !idx_last) begin
      idx <= idx + 1'b1;
    end
    if (state == S_WAIT && div_stat.done) begin
      k <= IDX_W'(div_rem);
    end
    if (state == S_WR_A) begin
      tmp <= ram_rdata0;
    end
    if (state == S_WR_B) begin
      if (n == LEN_W'(1)) begin
        idx <= '0;
      end else begin
        n <= n - 1'b1;
      end
    end
    if (out_load && !idx_last) begin
      idx <= idx + 1'b1;
    end
  end

  // Read data is good from the cycle after S_OUT is entered
  always_ff @(posedge clk) begin
    if (rst) begin
      rd_valid <= 1'b0;
    end else begin
      rd_valid <= (state == S_OUT);
    end
  end

  // Output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (out_load) begin
      out_valid <= 1'b1;
    end else if (rsp.ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      out_position <= POS_W'(idx);
      out_element  <= ELEM_W'(ram_rdata0);
      out_last     <= idx_last;
    end
  end

  assign rsp.valid    = out_valid;
  assign rsp.position = out_position;
  assign rsp.element  = out_element;
  assign rsp.last     = out_last;

  // Working permutation
  pru_ram #(
    .WIDTH (IDX_W),
    .DEPTH (MAX_ELEMENTS)
  ) u_perm (
    .clk    (clk),
    .we     (ram_we),
    .waddr  (ram_waddr),
    .wdata  (ram_wdata),
    .raddr0 (ram_raddr0),
    .raddr1 (k),
    .rdata0 (ram_rdata0),
    .rdata1 (ram_rdata1)
  );

  // Shared divider: rank mod n and rank / n
  pru_div #(
    .DIV_W (LEN_W)
  ) u_div (
    .clk       (clk),
    .rst       (rst),
    .start     (div_start),
    .dividend  (work_rank),
    .divisor   (div_divisor),
    .stat      (div_stat),
    .quotient  (div_quot),
    .remainder (div_rem)
  );

  `PRU_ASSERT_IMP(a_wait_div, clk, rst, state == S_WAIT, div_stat.busy || div_stat.done, "waiting on an idle divider")
  `PRU_ASSERT_IMP(a_out_n_one, clk, rst, state == S_OUT, n == LEN_W'(1), "output phase before all steps ran")
  `PRU_ASSERT_IMP(a_last_pos, clk, rst, out_valid && out_last, out_position == POS_W'(len - 1'b1), "last flag on wrong position")
  `PRU_ASSERT_NXT(a_req_init, clk, rst, req_beat, state == S_INIT, "request beat did not start the identity fill")

endmodule

// ----- sim/permutation_unrank_unit_tb.sv -----
// ----------------------------------------------------------------------------
// Permutation unrank unit - testbench
// Drives ranks through the request channel under several length settings.
// It predicts the element beats in software, or takes them from the directed
// table, and checks each response beat in order. Both channels idle in random
// bursts, and the response side holds off once for a long stretch so that the
// unit backs up.
`timescale 1ns / 1ps

module permutation_unrank_unit_tb;
  import pru_pkg::*;

  localparam int MAX_ELEM    = 16;
  localparam int RST_CYCLES  = 8;
  localparam int CFG_PAUSE   = 40;
  localparam int TAIL_CYCLES = 300;
  localparam int HOLD_CYCLES = 800;
  localparam int CYCLE_LIMIT = 400000;
  localparam int PHASES      = 6;
  localparam int PHASE_ITEMS = 17;
  localparam int DIR_COUNT   = 18;
  localparam int MAX_REPORTS = 10;

  localparam logic [63:0]       IDENT_PERM = 64'hFEDC_BA98_7654_3210;
  localparam logic [RANK_W-1:0] RANK_ONES  = {RANK_W{1'b1}};

  // One element beat as it leaves the unit
  typedef struct packed {
    logic [POS_W-1:0]  position;
    logic [ELEM_W-1:0] element;
    logic              last;
  } elem_beat_t;

  // Directed row: optional length write, then one rank
  typedef struct packed {
    bit                cfg_wr;
    logic [CFG_W-1:0]  cfg_val;
    logic [RANK_W-1:0] rank;
    bit                typed;
    logic [63:0]       perm;
  } dir_row_t;

  localparam dir_row_t DIR_ROWS [DIR_COUNT] = '{
    '{1'b0, 5'd0,  45'd20922789887999, 1'b1, IDENT_PERM},
    '{1'b0, 5'd0,  45'd0,              1'b0, 64'h0},
    '{1'b0, 5'd0,  RANK_ONES,          1'b0, 64'h0},
    '{1'b1, 5'd1,  45'd0,              1'b1, 64'h0},
    '{1'b0, 5'd0,  RANK_ONES,          1'b1, 64'h0},
    '{1'b1, 5'd0,  45'd12345,          1'b1, 64'h0},
    '{1'b1, 5'd2,  45'd0,              1'b1, 64'h01},
    '{1'b0, 5'd0,  45'd1,              1'b1, 64'h10},
    '{1'b0, 5'd0,  RANK_ONES,          1'b1, 64'h10},
    '{1'b1, 5'd31, 45'd20922789887999, 1'b1, IDENT_PERM},
    '{1'b0, 5'd0,  45'd20922789888000, 1'b0, 64'h0},
    '{1'b1, 5'd17, 45'h1555_5555_5555, 1'b0, 64'h0},
    '{1'b1, 5'd15, 45'd1307674367999,  1'b1, IDENT_PERM},
    '{1'b0, 5'd0,  45'd2615348735999,  1'b1, IDENT_PERM},
    '{1'b0, 5'd0,  45'd1307674368000,  1'b0, 64'h0},
    '{1'b1, 5'd8,  45'd40319,          1'b1, IDENT_PERM},
    '{1'b0, 5'd0,  45'h0AAA_AAAA_AAAA, 1'b0, 64'h0},
    '{1'b1, 5'd16, 45'h1FFF_0000_FFFF, 1'b0, 64'h0}
  };

  logic clk = 1'b0;
  logic rst = 1'b1;

  pru_cfg_if  cfg_bus ();
  pru_rank_if rank_bus ();
  pru_elem_if elem_bus ();

  permutation_unrank_unit #(
    .MAX_ELEMENTS(MAX_ELEM)
  ) dut (
    .clk(clk),
    .rst(rst),
    .cfg(cfg_bus),
    .req(rank_bus),
    .rsp(elem_bus)
  );

  elem_beat_t        elem_expect_q [$];
  elem_beat_t        elem_want;
  logic [CFG_W-1:0]  length_reg = CFG_RESET;
  int                mismatch_cnt = 0;
  int                cycle_cnt = 0;
  bit                idle_on = 1'b1;
  bit                hold_off_req = 1'b0;
  int                hold_cnt;

  always #2 clk = ~clk;

  // Length register as the unit applies it
  function automatic int eff_length(input logic [CFG_W-1:0] v);
    if (v == '0) return 1;
    if (v > MAX_ELEM) return MAX_ELEM;
    return int'(v);
  endfunction

  function automatic logic [63:0] factorial(input int n);
    logic [63:0] f;
    f = 64'd1;
    for (int i = 2; i <= n; i++) f = f * i;
    return f;
  endfunction

  // Swap-and-divide unranking; result packed one nibble per position
  function automatic logic [63:0] unrank_perm(input logic [RANK_W-1:0] r, input int len);
    logic [ELEM_W-1:0] p [MAX_ELEM];
    logic [RANK_W-1:0] w;
    logic [RANK_W-1:0] nn;
    logic [ELEM_W-1:0] t;
    logic [63:0]       v;
    int                k;
    for (int i = 0; i < MAX_ELEM; i++) p[i] = ELEM_W'(i);
    w = r;
    for (int n = len; n > 0; n--) begin
      nn = RANK_W'(n);
      k = int'(w % nn);
      t = p[n-1];
      p[n-1] = p[k];
      p[k] = t;
      w = w / nn;
    end
    v = '0;
    for (int i = 0; i < len; i++) v[4*i +: 4] = p[i];
    return v;
  endfunction

  // Mostly ranks below len!, some raw 45-bit ranks, some boundaries
  function automatic logic [RANK_W-1:0] pick_rank(input int len);
    logic [63:0] raw;
    logic [63:0] f;
    int          pick;
    raw  = {$urandom, $urandom};
    f    = factorial(len);
    pick = $urandom_range(0, 9);
    if (pick < 5) return RANK_W'(raw % f);
    if (pick < 8) return RANK_W'(raw);
    case ($urandom_range(0, 3))
      0: return RANK_W'(f - 1);
      1: return RANK_W'(f);
      2: return '0;
      default: return RANK_ONES;
    endcase
  endfunction

  // Drain, pause, then write the length register; called at a falling edge
  task automatic write_length(input logic [CFG_W-1:0] v);
    rank_bus.valid <= 1'b0;
    while (elem_expect_q.size() != 0) @(negedge clk);
    repeat (CFG_PAUSE) @(negedge clk);
    cfg_bus.valid <= 1'b1;
    cfg_bus.data  <= v;
    do @(posedge clk); while (!cfg_bus.ready);
    length_reg = v;
    @(negedge clk);
    cfg_bus.valid <= 1'b0;
  endtask

  // Offer one rank beat and queue its elements once accepted
  task automatic send_rank(input logic [RANK_W-1:0] r, input bit typed,
                           input logic [63:0] typed_perm);
    logic [63:0] perm;
    int          len;
    int          gap;
    elem_beat_t  beat;
    if (idle_on && $urandom_range(0, 3) == 0) begin
      gap = $urandom_range(1, 9);
      rank_bus.valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    rank_bus.valid <= 1'b1;
    rank_bus.rank  <= r;
    do @(posedge clk); while (!rank_bus.ready);
    len  = eff_length(length_reg);
    perm = typed ? typed_perm : unrank_perm(r, len);
    for (int i = 0; i < len; i++) begin
      beat.position = POS_W'(i);
      beat.element  = perm[4*i +: 4];
      beat.last     = (i == len - 1);
      elem_expect_q = {elem_expect_q, beat};
    end
    @(negedge clk);
  endtask

  // Response side: random stalls, plus one long hold-off on request
  initial begin
    elem_bus.ready = 1'b0;
    forever begin
      @(negedge clk);
      if (hold_off_req) begin
        hold_off_req = 1'b0;
        elem_bus.ready <= 1'b0;
        for (hold_cnt = 0; hold_cnt < HOLD_CYCLES; hold_cnt++) @(negedge clk);
      end else if (idle_on && $urandom_range(0, 4) == 0) begin
        elem_bus.ready <= 1'b0;
        repeat ($urandom_range(1, 9) - 1) @(negedge clk);
      end else begin
        elem_bus.ready <= 1'b1;
      end
    end
  end

  // Compare every accepted element beat with the oldest expectation
  always @(posedge clk) begin
    if (!rst && elem_bus.valid && elem_bus.ready) begin
      if (elem_expect_q.size() == 0) begin
        mismatch_cnt++;
        if (mismatch_cnt <= MAX_REPORTS)
          $display("Unexpected element beat: pos %0d elem %0d last %0b",
                   elem_bus.position, elem_bus.element, elem_bus.last);
      end else begin
        elem_want = elem_expect_q.pop_front();
        if (elem_bus.position !== elem_want.position ||
            elem_bus.element  !== elem_want.element  ||
            elem_bus.last     !== elem_want.last) begin
          mismatch_cnt++;
          if (mismatch_cnt <= MAX_REPORTS)
            $display({"Element mismatch: expected pos %0d elem %0d last %0b, ",
                      "got pos %0d elem %0d last %0b"},
                     elem_want.position, elem_want.element, elem_want.last,
                     elem_bus.position, elem_bus.element, elem_bus.last);
        end
      end
    end
  end

  // Stop a hung run
  always @(posedge clk) begin
    cycle_cnt <= cycle_cnt + 1;
    if (cycle_cnt == CYCLE_LIMIT) begin
      $display("Simulation FAILED");
      $finish;
    end
  end

  // Stimulus: directed table, then random phases
  initial begin
    logic [CFG_W-1:0] len_val;
    cfg_bus.valid  = 1'b0;
    cfg_bus.data   = '0;
    rank_bus.valid = 1'b0;
    rank_bus.rank  = '0;
    repeat (RST_CYCLES) @(negedge clk);
    rst <= 1'b0;

    // Walk the directed table
    for (int i = 0; i < DIR_COUNT; i++) begin
      if (DIR_ROWS[i].cfg_wr) write_length(DIR_ROWS[i].cfg_val);
      send_rank(DIR_ROWS[i].rank, DIR_ROWS[i].typed, DIR_ROWS[i].perm);
    end

    // Random phases, one length each; long hold-off in one, quiet in phase 3 and the last
    for (int ph = 0; ph < PHASES; ph++) begin
      case (ph)
        1:       len_val = 5'd1;
        4:       len_val = 5'd31;
        default: len_val = CFG_W'($urandom_range(0, 31));
      endcase
      write_length(len_val);
      idle_on = (ph != 3) && (ph != PHASES - 1);
      if (ph == 2) hold_off_req = 1'b1;
      for (int k = 0; k < PHASE_ITEMS; k++)
        send_rank(pick_rank(eff_length(length_reg)), 1'b0, 64'h0);
    end

    // Drain and let any stray beats show up
    rank_bus.valid <= 1'b0;
    while (elem_expect_q.size() != 0) @(negedge clk);
    repeat (TAIL_CYCLES) @(negedge clk);
    if (mismatch_cnt == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule

// ----- files.f -----
+incdir+sv
sv/pru_pkg.sv
sv/pru_if.sv
sv/pru_ram.sv
sv/pru_div.sv
sv/permutation_unrank_unit.sv
sim/permutation_unrank_unit_tb.sv
